### design/ptdc_pkg.sv
package ptdc_pkg;

    // Character codes
    localparam logic [7:0] CHAR_SLASH = 8'd47;
    localparam logic [7:0] CHAR_DOT   = 8'd46;

    // Depth counter saturates here
    localparam int unsigned DEPTH_MAX = 1023;
    localparam int unsigned DEPTH_W   = $clog2(DEPTH_MAX + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(DEPTH_MAX);

    localparam int unsigned DATA_W = 8;

    // Kind of the open segment
    typedef enum logic [1:0] {
        KIND_EMPTY  = 2'd0,
        KIND_DOT    = 2'd1,
        KIND_DOTDOT = 2'd2,
        KIND_OTHER  = 2'd3
    } t_kind;

    // One path character with its end marker
    typedef struct packed {
        logic [7:0] path_byte;
        logic       last_byte;
    } t_item;

    // Handoff from the tracker to the result register
    typedef struct packed {
        logic load;
        logic verdict;
    } t_result;

    // Kind after one more non-slash character
    function automatic t_kind next_kind(input t_kind kind, input logic [7:0] ch);
        t_kind k;
        begin
            k = KIND_OTHER;
            if (ch == CHAR_DOT) begin
                case (kind)
                    KIND_EMPTY: k = KIND_DOT;
                    KIND_DOT:   k = KIND_DOTDOT;
                    default:    k = KIND_OTHER;
                endcase
            end
            return k;
        end
    endfunction

    // Depth after closing a segment of the given kind
    function automatic logic [DEPTH_W-1:0] close_depth(input logic [DEPTH_W-1:0] depth,
                                                      input t_kind kind);
        logic [DEPTH_W-1:0] d;
        begin
            d = depth;
            if (kind == KIND_DOTDOT) begin
                if (depth != '0) d = depth - DEPTH_W'(1);
            end else if (kind == KIND_OTHER) begin
                if (depth < DEPTH_TOP) d = depth + DEPTH_W'(1);
            end
            return d;
        end
    endfunction

endpackage

### design/ptdc_in_reg.sv
module ptdc_in_reg
    import ptdc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  logic  i_adv,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    // Fill on a request, empty when the tracker consumes
    always_comb begin
        n_valid = r_valid;
        if (i_load)     n_valid = 1'b1;
        else if (i_adv) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold payload until the next request
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### design/ptdc_tracker.sv
module ptdc_tracker
    import ptdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    output t_result o_result
);

    logic               r_seen;
    t_kind              r_kind;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_alert;

    logic               n_seen;
    t_kind              n_kind;
    logic [DEPTH_W-1:0] n_depth;
    logic               n_alert;

    // Classify the character and close segments
    always_comb begin
        logic               is_slash;
        logic               last;
        logic [DEPTH_W-1:0] d1;
        begin
            is_slash = (i_item.path_byte == CHAR_SLASH);
            last     = i_item.last_byte;
            n_seen   = r_seen;
            n_kind   = r_kind;
            n_depth  = r_depth;
            n_alert  = r_alert;
            d1       = r_depth;
            if (is_slash) begin
                // close the open segment, then on a final slash the trailing empty one
                if (r_seen) begin
                    d1 = close_depth(r_depth, r_kind);
                    if (d1 == '0) n_alert = 1'b1;
                end
                n_seen  = 1'b1;
                n_kind  = KIND_EMPTY;
                n_depth = d1;
                if (last && d1 == '0) n_alert = 1'b1;
            end else if (r_seen) begin
                n_kind = next_kind(r_kind, i_item.path_byte);
                if (last) begin
                    n_depth = close_depth(r_depth, n_kind);
                    if (n_depth == '0) n_alert = 1'b1;
                end
            end
            o_result.load    = i_adv && last;
            o_result.verdict = !n_alert;
        end
    end

    // Advance per character, clear after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_kind  <= KIND_EMPTY;
            r_depth <= '0;
            r_alert <= 1'b0;
        end else if (i_adv) begin
            if (i_item.last_byte) begin
                r_seen  <= 1'b0;
                r_kind  <= KIND_EMPTY;
                r_depth <= '0;
                r_alert <= 1'b0;
            end else begin
                r_seen  <= n_seen;
                r_kind  <= n_kind;
                r_depth <= n_depth;
                r_alert <= n_alert;
            end
        end
    end

endmodule

### design/ptdc_out_reg.sv
module ptdc_out_reg
    import ptdc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_result i_result,
    input  logic    i_take,
    output logic    o_valid,
    output logic    o_verdict
);

    logic r_valid;
    logic n_valid;
    logic r_verdict;

    // Keep the verdict until the receiver takes it
    always_comb begin
        n_valid = r_valid;
        if (i_result.load) n_valid = 1'b1;
        else if (i_take)   n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.load) begin
            r_verdict <= i_result.verdict;
        end
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

endmodule

### design/path_traversal_depth_check_core.sv
// Path traversal depth check.
// Slave channel: one path character per request, i_s_tdata holds the byte and
// i_s_tlast marks the final character of a path. Master channel: one request
// per path, o_m_tdata[0] holds the verdict (1 safe, 0 traversal alert).
// Characters before the first slash are skipped; each later segment moves a
// nesting depth counter (".." down to zero, "." and empty hold, others up to
// a saturation limit), and a depth of zero after any segment flags an alert.
// Flow: a final character passes the input register, then the tracker into
// the result register, where its verdict is offered.
// Throughput: one character per cycle but for the stall below; the depth
// tracker clears at each final character, so paths may follow without gaps.
// Reset: clears the input register, the tracker state and the result valid.
// Stall: while a verdict waits, non-final characters still flow through the
// tracker; a final character waits in the input register until the result
// register frees, and o_s_tready drops only then.
module path_traversal_depth_check_core
    import ptdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [DATA_W-1:0] i_s_tdata,   // [7:0] path_byte
    input  logic              i_s_tlast,   // last_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_m_tdata    // [0] verdict, [7:1] zero
);

    logic    in_valid;
    t_item   in_item;
    t_item   s_item;
    t_result result;
    logic    out_valid;
    logic    out_verdict;
    logic    adv;
    logic    load;

    // Advance the held character unless its verdict has no room
    assign adv  = in_valid && (!in_item.last_byte || !out_valid || i_m_tready);
    assign o_s_tready = !in_valid || adv;
    assign load = i_s_tvalid && o_s_tready;

    assign s_item.path_byte = i_s_tdata;
    assign s_item.last_byte = i_s_tlast;

    ptdc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_adv   (adv),
        .i_item  (s_item),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    ptdc_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (in_item),
        .o_result (result)
    );

    ptdc_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_result  (result),
        .i_take    (i_m_tready),
        .o_valid   (out_valid),
        .o_verdict (out_verdict)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {{(DATA_W-1){1'b0}}, out_verdict};

endmodule

### design/ptdc_checker.sv
module ptdc_checker
    import ptdc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic [DATA_W-1:0] i_s_tdata,
    input logic              i_s_tlast,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [DATA_W-1:0] o_m_tdata
);

    // Offered verdict stays until taken
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("verdict dropped while stalled");

    // Offered verdict keeps its value until taken
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("verdict changed while stalled");

    // Nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("verdict offered after reset");

    // A fresh verdict follows a taken final character through both registers
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tlast, 2))
        else $error("verdict without a final character");

endmodule

bind path_traversal_depth_check_core ptdc_checker u_ptdc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### test/tb_path_traversal_depth_check_core.sv
module tb_path_traversal_depth_check_core;
    import ptdc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_CHARS = 2000;
    localparam int unsigned MAX_GAP      = 17;
    localparam int unsigned DRAIN_CYCLES = 10;

    // Track nesting depth per path and hold the verdicts still owed by the block
    class verdict_scoreboard;
        bit                 slash_seen;
        t_kind              open_kind;
        logic [DEPTH_W-1:0] depth;
        bit                 alert;
        logic               pending_verdicts[$];
        int unsigned        errors;
        int unsigned        chars_taken;
        int unsigned        safe_paths;
        int unsigned        alert_paths;

        function void clear_path();
            slash_seen = 1'b0;
            open_kind  = KIND_EMPTY;
            depth      = '0;
            alert      = 1'b0;
        endfunction

        // Move the depth for a closed segment and latch an alert at the root
        function void settle_segment(t_kind kind);
            if (kind == KIND_DOTDOT && depth != '0)
                depth = depth - 1'b1;
            else if (kind == KIND_OTHER && depth != DEPTH_TOP)
                depth = depth + 1'b1;
            if (depth == '0)
                alert = 1'b1;
        endfunction

        function t_kind grow_kind(t_kind kind, logic [7:0] ch);
            if (ch != CHAR_DOT)
                return KIND_OTHER;
            if (kind == KIND_EMPTY)
                return KIND_DOT;
            if (kind == KIND_DOT)
                return KIND_DOTDOT;
            return KIND_OTHER;
        endfunction

        function void note_char(logic [7:0] ch, logic last);
            chars_taken++;
            if (ch == CHAR_SLASH) begin
                if (slash_seen)
                    settle_segment(open_kind);
                slash_seen = 1'b1;
                open_kind  = KIND_EMPTY;
                // A trailing slash also closes the empty segment after it
                if (last)
                    settle_segment(KIND_EMPTY);
            end else if (slash_seen) begin
                open_kind = grow_kind(open_kind, ch);
                if (last)
                    settle_segment(open_kind);
            end
            if (last) begin
                pending_verdicts.push_back(!alert);
                clear_path();
            end
        endfunction

        function void report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s: expected verdict byte %h, got %h", what, want, got);
        endfunction

        function void check_verdict(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (pending_verdicts.size() == 0) begin
                report("verdict with no path pending", 'x, got);
                return;
            end
            want = {{(DATA_W-1){1'b0}}, pending_verdicts.pop_front()};
            if (got !== want)
                report("verdict mismatch", want, got);
            if (want[0])
                safe_paths++;
            else
                alert_paths++;
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata  = '0;   // [7:0] path_byte
    logic              i_s_tlast  = 1'b0; // last_byte
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [DATA_W-1:0] o_m_tdata;         // [0] verdict, [7:1] zero

    verdict_scoreboard board = new();
    logic [7:0]        path_buf[$];
    bit                steady_stream = 1'b0;
    int unsigned       cycle_count = 0;
    int unsigned       paths_sent = 0;

    path_traversal_depth_check_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("path_traversal_depth_check_core verification failed");
            $finish;
        end
    end

    // Watch both channels and feed the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                board.note_char(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready)
                board.check_verdict(o_m_tdata);
        end
    end

    // Stall the verdict channel a random number of cycles before each verdict
    initial begin
        int unsigned gap;
        repeat (3) @(posedge i_clk);
        forever begin
            gap = steady_stream ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    // Offer one character and hold it until the request is taken
    task automatic send_char(input logic [7:0] ch, input logic last);
        int unsigned gap;
        gap = steady_stream ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= ch;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_path_buf();
        for (int i = 0; i < path_buf.size(); i++)
            send_char(path_buf[i], i == path_buf.size() - 1);
        paths_sent++;
    endtask

    task automatic send_text(input string s);
        path_buf.delete();
        for (int i = 0; i < s.len(); i++)
            path_buf.push_back(s[i]);
        send_path_buf();
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(0, 255));
        while (ch == CHAR_SLASH || ch == CHAR_DOT);
        return ch;
    endfunction

    // Build a mostly well-formed path; some are raw noise over slash, dot and any byte
    function automatic void build_random_path();
        int unsigned nseg;
        int unsigned len;
        int unsigned pick;
        path_buf.delete();
        if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, 8);
            repeat (len) begin
                pick = $urandom_range(0, 2);
                path_buf.push_back(pick == 0 ? CHAR_SLASH : pick == 1 ? CHAR_DOT :
                                   8'($urandom_range(0, 255)));
            end
            return;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) path_buf.push_back(plain_char());
        nseg = $urandom_range(0, 6);
        repeat (nseg) begin
            path_buf.push_back(CHAR_SLASH);
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3: begin
                    len = $urandom_range(1, 3);
                    repeat (len)
                        path_buf.push_back($urandom_range(0, 5) == 0 ? CHAR_DOT : plain_char());
                end
                4, 5: begin
                    path_buf.push_back(CHAR_DOT);
                    path_buf.push_back(CHAR_DOT);
                end
                6: path_buf.push_back(CHAR_DOT);
                7: ;
                8: repeat (3) path_buf.push_back(CHAR_DOT);
                default: begin
                    path_buf.push_back(CHAR_DOT);
                    path_buf.push_back(plain_char());
                end
            endcase
        end
        if ($urandom_range(0, 4) == 0)
            path_buf.push_back(CHAR_SLASH);
        if (path_buf.size() == 0)
            path_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    initial begin
        board.clear_path();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: root only, no slash, dots, empty segments, trailing slash
        send_text("/");
        send_text("abc");
        send_text("/a/");
        send_text("/a/..");
        send_text("/./a");
        send_text("//a");
        send_text("a/b");
        send_text("/.../.a/a..");
        send_text("/a/b/../");

        // Zero byte is an ordinary character; all-ones byte too
        path_buf = '{CHAR_SLASH, 8'h00, 8'hFF};
        send_path_buf();

        // Random paths, with occasional stretches of back-to-back traffic
        while (board.chars_taken < RANDOM_CHARS) begin
            if (paths_sent % 16 == 0)
                steady_stream = ($urandom_range(0, 3) == 0);
            build_random_path();
            send_path_buf();
        end
        i_s_tvalid <= 1'b0;
        steady_stream = 1'b0;

        // Drain outstanding verdicts, then watch for strays
        while (board.pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d paths, %0d characters: directed corner paths, then random ones.",
                 paths_sent, board.chars_taken);
        $display("Verdicts checked: %0d safe, %0d alert; %0d errors, %0d still owed.",
                 board.safe_paths, board.alert_paths, board.errors,
                 board.pending_verdicts.size());
        if (board.errors == 0 && board.pending_verdicts.size() == 0)
            $display("path_traversal_depth_check_core verification clean");
        else
            $display("path_traversal_depth_check_core verification failed");
        $finish;
    end

endmodule
